@@ design/sdf_pkg.sv @@
// ----------------------------------------------------------------------------
// sdf_pkg
// Shared types, character codes and helpers for the grouped decimal formatter.
// ----------------------------------------------------------------------------
package sdf_pkg;

    localparam int VALUE_W    = 32;
    localparam int CHAR_W     = 8;
    localparam int NUM_DIGITS = 10;
    localparam int GROUP_LEN  = 3;
    localparam int BCD_W      = 4 * NUM_DIGITS;
    localparam int CNT_W      = $clog2(VALUE_W);
    localparam int POS_W      = $clog2(NUM_DIGITS);

    localparam logic [CHAR_W-1:0] MINUS_CHAR = 8'd45;
    localparam logic [CHAR_W-1:0] ZERO_CHAR  = 8'd48;
    localparam logic [CHAR_W-1:0] SEP_RESET  = 8'd95;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_EMIT
    } sdf_state_t;

    // add-3 correction of one bcd digit before the shift
    function automatic logic [3:0] bcd_adjust(input logic [3:0] d);
        logic [3:0] r;
        r = (d >= 4'd5) ? 4'(d + 4'd3) : d;
        return r;
    endfunction

    // digit position modulo the group length
    function automatic logic [1:0] pos_mod3(input logic [POS_W-1:0] p);
        logic [1:0] r;
        case (p)
            4'd1, 4'd4, 4'd7: r = 2'd1;
            4'd2, 4'd5, 4'd8: r = 2'd2;
            default:          r = 2'd0;
        endcase
        return r;
    endfunction

endpackage

@@ design/sdf_if.sv @@
// ----------------------------------------------------------------------------
// sdf_if
// Valid/ready channels of the formatter: number in, text out, configuration.
// ----------------------------------------------------------------------------
interface sdf_num_if
    import sdf_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface sdf_text_if
    import sdf_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] text_char;
    logic              last;

    modport source (output valid, output text_char, output last, input ready);
    modport sink   (input valid, input text_char, input last, output ready);
endinterface

interface sdf_cfg_if
    import sdf_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] group_separator;

    modport source (output valid, output group_separator, input ready);
    modport sink   (input valid, input group_separator, output ready);
endinterface

@@ design/signed_decimal_formatter_grouped_top.sv @@
// ----------------------------------------------------------------------------
// signed_decimal_formatter_grouped_top
// Signed 32-bit integer to grouped decimal ascii text, bit-serial conversion.
// ----------------------------------------------------------------------------
// conversion: a 32-step shift-add-3 bcd loop, then a leading-zero skip, then one
//   output character per cycle while text.ready allows; a new number is taken
//   only in idle, once the last character of the previous one is loaded
// reset: idle, no pending text, group separator back to '_'
module signed_decimal_formatter_grouped_top
    import sdf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    sdf_num_if.sink     num,
    sdf_text_if.source  text,
    sdf_cfg_if.sink     cfg
);

    sdf_state_t        state_reg, state_next;
    logic [VALUE_W-1:0] mag_reg, mag_next;
    logic [BCD_W-1:0]  bcd_reg, bcd_next;
    logic [BCD_W-1:0]  bcd_adj;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [1:0]        grp_reg, grp_next;
    logic              neg_reg, neg_next;
    logic              first_reg, first_next;
    logic              sep_done_reg, sep_done_next;
    logic [CHAR_W-1:0] sep_reg;
    logic              out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0] out_char_reg, out_char_next;
    logic              out_last_reg, out_last_next;
    logic              load;

    assign num.ready      = (state_reg == ST_IDLE);
    assign cfg.ready      = 1'b1;
    assign text.valid     = out_valid_reg;
    assign text.text_char = out_char_reg;
    assign text.last      = out_last_reg;

    always_comb
    begin
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            bcd_adj[4*i +: 4] = bcd_adjust(bcd_reg[4*i +: 4]);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        mag_next       = mag_reg;
        bcd_next       = bcd_reg;
        cnt_next       = cnt_reg;
        pos_next       = pos_reg;
        grp_next       = grp_reg;
        neg_next       = neg_reg;
        first_next     = first_reg;
        sep_done_next  = sep_done_reg;
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        load           = !out_valid_reg || text.ready;

        if (out_valid_reg && text.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (num.valid)
                begin
                    neg_next   = num.value[VALUE_W-1];
                    mag_next   = num.value[VALUE_W-1] ? VALUE_W'(~num.value + 1'b1)
                                                      : VALUE_W'(num.value);
                    bcd_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                bcd_next = {bcd_adj[BCD_W-2:0], mag_reg[VALUE_W-1]};
                mag_next = {mag_reg[VALUE_W-2:0], 1'b0};
                cnt_next = CNT_W'(cnt_reg + 1'b1);
                if (cnt_reg == CNT_W'(VALUE_W - 1))
                begin
                    pos_next   = POS_W'(NUM_DIGITS - 1);
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                // drop leading zeros, keep at least one digit
                if (bcd_reg[BCD_W-1 -: 4] == 4'd0 && pos_reg != '0)
                begin
                    bcd_next = {bcd_reg[BCD_W-5:0], 4'd0};
                    pos_next = POS_W'(pos_reg - 1'b1);
                end
                else
                begin
                    grp_next      = pos_mod3(pos_reg);
                    first_next    = 1'b1;
                    sep_done_next = 1'b0;
                    state_next    = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (load)
                begin
                    out_valid_next = 1'b1;
                    if (neg_reg)
                    begin
                        out_char_next = MINUS_CHAR;
                        out_last_next = 1'b0;
                        neg_next      = 1'b0;
                    end
                    else if (!first_reg && grp_reg == 2'(GROUP_LEN - 1) && !sep_done_reg)
                    begin
                        out_char_next = sep_reg;
                        out_last_next = 1'b0;
                        sep_done_next = 1'b1;
                    end
                    else
                    begin
                        out_char_next = CHAR_W'(ZERO_CHAR + {4'd0, bcd_reg[BCD_W-1 -: 4]});
                        out_last_next = (pos_reg == '0);
                        bcd_next      = {bcd_reg[BCD_W-5:0], 4'd0};
                        pos_next      = (pos_reg == '0) ? pos_reg
                                                        : POS_W'(pos_reg - 1'b1);
                        grp_next      = (grp_reg == 2'd0) ? 2'(GROUP_LEN - 1)
                                                          : 2'(grp_reg - 1'b1);
                        first_next    = 1'b0;
                        sep_done_next = 1'b0;
                        if (pos_reg == '0)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            pos_reg       <= '0;
            grp_reg       <= '0;
            neg_reg       <= 1'b0;
            first_reg     <= 1'b0;
            sep_done_reg  <= 1'b0;
            sep_reg       <= SEP_RESET;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            pos_reg       <= pos_next;
            grp_reg       <= grp_next;
            neg_reg       <= neg_next;
            first_reg     <= first_next;
            sep_done_reg  <= sep_done_next;
            out_valid_reg <= out_valid_next;
            out_last_reg  <= out_last_next;
            if (cfg.valid && cfg.ready)
            begin
                sep_reg <= cfg.group_separator;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg      <= mag_next;
        bcd_reg      <= bcd_next;
        out_char_reg <= out_char_next;
    end

    // a pending non-final character means the number is still being emitted
    a_nonlast_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_last_reg |-> state_reg != ST_IDLE)
        else $error("non-final character pending while idle");

    a_accept_conv: assert property (@(posedge clk) disable iff (!rst_n)
        num.valid && num.ready |=> state_reg == ST_CONV && cnt_reg == '0)
        else $error("accepted number did not start conversion");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_W'(NUM_DIGITS - 1) && grp_reg <= 2'(GROUP_LEN - 1))
        else $error("digit position or group counter out of range");

    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT && state_next == ST_IDLE |=> out_valid_reg && out_last_reg)
        else $error("final digit not flagged last");

endmodule

@@ sim/tb_signed_decimal_formatter_grouped_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_signed_decimal_formatter_grouped_top
// Drives signed numbers into the grouped decimal formatter and scores every
// text beat against an in-bench formatter or typed text. A short table
// covers extremes and digit-count boundaries at the reset separator. Random
// numbers follow under several separators, with random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_signed_decimal_formatter_grouped_top;
    import sdf_pkg::*;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } text_beat_t;

    localparam int NUM_ROWS   = 25;
    localparam int NUM_PHASES = 8;
    localparam int PHASE_LEN  = 11;

    logic clk;
    logic rst_n;

    sdf_num_if  num_if ();
    sdf_text_if text_if ();
    sdf_cfg_if  cfg_if ();

    signed_decimal_formatter_grouped_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .num   (num_if),
        .text  (text_if),
        .cfg   (cfg_if)
    );

    text_beat_t        pending_text[$];
    logic [CHAR_W-1:0] group_sep;
    bit                burst;
    int                stall_left;
    int                failures;
    int                numbers_sent;
    int                chars_checked;

    logic [VALUE_W-1:0] dir_value [NUM_ROWS] = '{
        32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd999,
        32'd1000, -32'sd1000, 32'd9999, 32'd12345, 32'd123456, 32'd999999,
        32'd1000000, -32'sd1234567, 32'd99999999, 32'd100000000,
        32'd999999999, 32'd1000000000, 32'h7FFF_FFFF, 32'h8000_0000,
        32'h8000_0001, 32'h5555_5555, 32'hAAAA_AAAA
    };
    string dir_text [NUM_ROWS] = '{
        "0", "1", "-1", "", "", "", "", "",
        "1_000", "-1_000", "", "", "", "",
        "", "", "", "",
        "", "", "2_147_483_647", "-2_147_483_648",
        "-2_147_483_647", "", ""
    };
    logic [CHAR_W-1:0] sep_values [NUM_PHASES] = '{
        8'h2C, 8'h00, 8'hFF, MINUS_CHAR, ZERO_CHAR, 8'hA5, 8'h5A, SEP_RESET
    };

    always #10 clk = ~clk;

    initial
    begin
        #(10_000_000);
        $display("status: fail");
        $finish;
    end

    // expected text of one number under the current separator
    function automatic void format_grouped(input logic [VALUE_W-1:0] v);
        logic [VALUE_W-1:0] mag;
        logic [3:0]         digs [NUM_DIGITS];
        int                 nd;
        int                 pos;
        mag = v[VALUE_W-1] ? -v : v;
        nd  = 0;
        if (mag == 0)
        begin
            digs[0] = 4'd0;
            nd      = 1;
        end
        else
        begin
            while (mag != 0)
            begin
                digs[nd] = 4'(mag % 10);
                nd++;
                mag = mag / 10;
            end
        end
        if (v[VALUE_W-1])
            pending_text.push_back('{MINUS_CHAR, 1'b0});
        for (pos = nd - 1; pos >= 0; pos--)
        begin
            if (pos != nd - 1 && pos % GROUP_LEN == GROUP_LEN - 1)
                pending_text.push_back('{group_sep, 1'b0});
            pending_text.push_back('{ZERO_CHAR + CHAR_W'(digs[pos]), pos == 0});
        end
    endfunction

    // mostly short, now and then long
    function automatic int rand_gap();
        int r;
        r = $urandom_range(99, 0);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(3, 1);
        else if (r < 97)
            return $urandom_range(10, 4);
        else
            return $urandom_range(60, 20);
    endfunction

    // spread over digit counts, signs, edges and raw bit patterns
    function automatic logic [VALUE_W-1:0] rand_value();
        int                 r;
        int                 n;
        int unsigned        lo;
        int unsigned        hi;
        logic [VALUE_W-1:0] mag;
        r = $urandom_range(99, 0);
        if (r < 10)
            return $urandom;
        if (r < 16)
        begin
            case ($urandom_range(5, 0))
                0:       return 32'd0;
                1:       return 32'd1;
                2:       return 32'hFFFF_FFFF;
                3:       return 32'h7FFF_FFFF;
                4:       return 32'h8000_0000;
                default: return 32'h8000_0001;
            endcase
        end
        n  = $urandom_range(10, 1);
        lo = 1;
        for (int i = 1; i < n; i++)
            lo = lo * 10;
        hi = (n == 10) ? 32'h7FFF_FFFF : lo * 10 - 1;
        if (n == 1)
            lo = 0;
        mag = $urandom_range(hi, lo);
        return $urandom_range(1, 0) ? -mag : mag;
    endfunction

    task automatic wait_text_drained();
        num_if.valid <= 1'b0;
        while (pending_text.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_number(input logic [VALUE_W-1:0] v, input string typed);
        int gap;
        gap = burst ? 0 : rand_gap();
        if (gap > 0)
        begin
            num_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        num_if.valid <= 1'b1;
        num_if.value <= v;
        @(posedge clk);
        while (!num_if.ready)
            @(posedge clk);
        if (typed.len() == 0)
            format_grouped(v);
        else
            for (int i = 0; i < typed.len(); i++)
                pending_text.push_back('{CHAR_W'(typed[i]), i == typed.len() - 1});
        numbers_sent++;
    endtask

    task automatic write_separator(input logic [CHAR_W-1:0] s);
        wait_text_drained();
        repeat (8) @(posedge clk);
        cfg_if.valid           <= 1'b1;
        cfg_if.group_separator <= s;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        cfg_if.valid <= 1'b0;
        group_sep = s;
    endtask

    task automatic check_text_beat(input logic [CHAR_W-1:0] ch, input logic last);
        text_beat_t want;
        if (pending_text.size() == 0)
        begin
            $error("unexpected text beat: text_char %0d last %0d", ch, last);
            failures++;
            return;
        end
        want = pending_text.pop_front();
        chars_checked++;
        if (ch !== want.ch)
        begin
            $error("text_char mismatch: expected %0d actual %0d", want.ch, ch);
            failures++;
        end
        if (last !== want.last)
        begin
            $error("last mismatch: expected %0d actual %0d", want.last, last);
            failures++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_if.ready <= 1'b0;
            stall_left    <= 0;
        end
        else
        begin
            if (text_if.valid && text_if.ready)
                check_text_beat(text_if.text_char, text_if.last);
            if (stall_left > 0)
            begin
                text_if.ready <= 1'b0;
                stall_left    <= stall_left - 1;
            end
            else if (!burst && $urandom_range(3, 0) == 0)
            begin
                text_if.ready <= 1'b0;
                stall_left    <= rand_gap();
            end
            else
                text_if.ready <= 1'b1;
        end
    end

    initial
    begin
        clk                    = 1'b0;
        burst                  = 1'b0;
        group_sep              = SEP_RESET;
        failures               = 0;
        numbers_sent           = 0;
        chars_checked          = 0;
        rst_n                  <= 1'b0;
        num_if.valid           <= 1'b0;
        num_if.value           <= '0;
        cfg_if.valid           <= 1'b0;
        cfg_if.group_separator <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        for (int i = 0; i < NUM_ROWS; i++)
            send_number(dir_value[i], dir_text[i]);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_separator(sep_values[p]);
            burst = (p == 2 || p == 5);
            for (int j = 0; j < PHASE_LEN; j++)
                send_number(rand_value(), "");
            burst = 1'b0;
        end

        wait_text_drained();
        repeat (60) @(posedge clk);

        $display("covered %0d numbers, %0d text beats, %0d separator settings plus reset",
                 numbers_sent, chars_checked, NUM_PHASES);
        if (failures == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
